// File: rtl/core/bba_pkg.sv
// shared types and constants of the block bitmap allocator
package bba_pkg;

  // map geometry
  localparam int NUM_BLOCKS    = 1024;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = NUM_BLOCKS / MAP_WORD_BITS;
  localparam int WORD_ADDR_W   = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);

  // field widths
  localparam int MODE_W  = 2;
  localparam int BLOCK_W = 10;
  localparam int COUNT_W = 11;

  // request modes
  localparam logic [MODE_W-1:0] MODE_MARK_FREE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK_BUSY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_FREE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CHECK_FREE = 2'd3;

  // one request item
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BLOCK_W-1:0] block_number;
    logic [COUNT_W-1:0] required_count;
  } req_item_t;

  // one response item
  typedef struct packed {
    logic [COUNT_W-1:0] free_count;
    logic               found;
    logic [BLOCK_W-1:0] found_block;
    logic               has_enough;
    logic               out_of_range;
  } rsp_item_t;

endpackage

// File: rtl/core/block_bitmap_allocator.sv
// block bitmap allocator: free/busy map of storage blocks with a free count
//
// The map sits in one ram of MAP_WORDS words of MAP_WORD_BITS bits, one bit
// per block (1 = free). The block takes one request at a time. A mark free or
// mark busy request is a read-modify-write of one map word; a mark that is out
// of range and a check of the free count are answered without touching the
// map. A search for the lowest free block reads one map word per cycle from
// word 0 and stops at the first word holding a free block in use, or after
// the last word that holds blocks in use. With no free block the search is
// skipped. Writing blocks_in_use (saturated to NUM_BLOCKS) formats the map: a
// valid bit per map word is cleared and a word that was never written since
// reads as all free, so no clearing pass is needed. Write the register only
// while no request is in flight. A response waits in its output register while
// stalled; the next request is still taken and worked on, and it then waits at
// its end until the output register is free.
module block_bitmap_allocator
  import bba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_item_t          req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_item_t          rsp,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MARK   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                 state;
  req_item_t              item;
  logic [WORD_ADDR_W-1:0] work_addr;
  logic [COUNT_W-1:0]     free_total;
  logic [COUNT_W-1:0]     active;
  logic [MAP_WORDS-1:0]   word_valid;
  logic                   res_found;
  logic [BLOCK_W-1:0]     res_block;
  logic                   res_oor;

  logic                     req_xfer;
  logic                     req_is_mark;
  logic                     req_oor;
  logic [WORD_ADDR_W-1:0]   map_raddr;
  logic [MAP_WORD_BITS-1:0] map_rdata;
  logic [MAP_WORD_BITS-1:0] eff_word;
  logic [MAP_WORD_BITS-1:0] new_word;
  logic [BIT_IDX_W-1:0]     bit_idx;
  logic                     cur_free;
  logic                     want_free;
  logic                     map_we;
  logic [MAP_WORD_BITS-1:0] use_mask;
  logic [MAP_WORD_BITS-1:0] hit_bits;
  logic [BIT_IDX_W-1:0]     hit_idx;
  logic [COUNT_W-1:0]       next_base;
  logic [COUNT_W-1:0]       cfg_sat;
  logic                     rsp_free;

  // request handshake
  assign req_stall   = (state != S_IDLE);
  assign req_xfer    = req_valid && !req_stall;
  assign req_is_mark = (req.mode == MODE_MARK_FREE) || (req.mode == MODE_MARK_BUSY);
  assign req_oor     = ({1'b0, req.block_number} >= active);
  assign rsp_free    = !rsp_valid || !rsp_stall;

  // saturated block count on a register write
  assign cfg_sat = (cfg_wdata > COUNT_W'(NUM_BLOCKS)) ? COUNT_W'(NUM_BLOCKS) : cfg_wdata;

  // map read address: first word of a request, then the scan walks on
  always_comb begin
    if (state == S_IDLE) begin
      map_raddr = req_is_mark ? req.block_number[BIT_IDX_W +: WORD_ADDR_W] : '0;
    end else begin
      map_raddr = work_addr + 1'b1;
    end
  end

  // word as held in the map, unwritten words read as all free
  assign eff_word = word_valid[work_addr] ? map_rdata : '1;

  // read-modify-write of one map bit
  assign bit_idx   = item.block_number[BIT_IDX_W-1:0];
  assign cur_free  = eff_word[bit_idx];
  assign want_free = (item.mode == MODE_MARK_FREE);
  assign map_we    = (state == S_MARK);
  always_comb begin
    new_word          = eff_word;
    new_word[bit_idx] = want_free;
  end

  // free bits of the scanned word that belong to blocks in use
  always_comb begin
    logic [BLOCK_W-1:0] gidx;
    gidx = '0;
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      gidx        = {work_addr, BIT_IDX_W'(j)};
      use_mask[j] = ({1'b0, gidx} < active);
    end
    hit_bits = eff_word & use_mask;
  end

  // lowest free bit of the scanned word
  always_comb begin
    hit_idx = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (hit_bits[j]) begin
        hit_idx = BIT_IDX_W'(j);
      end
    end
  end

  // first block of the next map word
  assign next_base = COUNT_W'({({1'b0, work_addr} + 1'b1), {BIT_IDX_W{1'b0}}});

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (work_addr),
    .wdata (new_word),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // sequencer, free count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      free_total <= COUNT_W'(NUM_BLOCKS);
      active     <= COUNT_W'(NUM_BLOCKS);
      word_valid <= '0;
    end else begin
      // response register: loaded at the end of a request, cleared once taken
      if ((state == S_FINISH) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            item      <= req;
            res_found <= 1'b0;
            res_block <= '0;
            res_oor   <= req_is_mark && req_oor;
            work_addr <= map_raddr;
            if (req_is_mark && !req_oor) begin
              state <= S_MARK;
            end else if ((req.mode == MODE_FIND_FREE) && (free_total != '0)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_MARK: begin
          word_valid[work_addr] <= 1'b1;
          if (cur_free != want_free) begin
            if (want_free && (free_total < active)) begin
              free_total <= free_total + 1'b1;
            end else if (!want_free && (free_total != '0)) begin
              free_total <= free_total - 1'b1;
            end
          end
          state <= S_FINISH;
        end
        S_SCAN: begin
          if (hit_bits != '0) begin
            res_found <= 1'b1;
            res_block <= {work_addr, hit_idx};
            state     <= S_FINISH;
          end else if (next_base >= active) begin
            state <= S_FINISH;
          end else begin
            work_addr <= map_raddr;
          end
        end
        S_FINISH: begin
          if (rsp_free) begin
            rsp.free_count   <= free_total;
            rsp.found        <= res_found;
            rsp.found_block  <= res_block;
            rsp.has_enough   <= (item.mode == MODE_CHECK_FREE) &&
                                (free_total >= item.required_count);
            rsp.out_of_range <= res_oor;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // register write formats the map
      if (cfg_we) begin
        active     <= cfg_sat;
        free_total <= cfg_sat;
        word_valid <= '0;
      end
    end
  end

`ifndef SYNTH
  // free count never exceeds the blocks in use
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= active)
    else $error("free count above blocks in use");

  // a transfer in makes the block busy on the next cycle
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    req_xfer && !cfg_we |=> req_stall)
    else $error("request side not stalled after a transfer");

  // a search only runs while some block is free
  a_scan_has_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (free_total != '0))
    else $error("search running with no free block");

  // a found block lies among the blocks in use
  a_found_in_use: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> ({1'b0, rsp.found_block} < active) && !rsp.out_of_range)
    else $error("found block outside the blocks in use");

  // an out of range mark reports nothing else
  a_oor_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_of_range |-> !rsp.found && !rsp.has_enough)
    else $error("out of range response with other flags set");
`endif

endmodule

// File: rtl/core/bba_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
